// File: sv/fpc_pkg.sv
// Package: shared widths, constants and types for the frustum plane cull block.
`default_nettype none

package fpc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    STEP_A,
    STEP_B,
    STEP_C,
    STEP_SUM
  } step_t;

  typedef struct packed {
    logic load_offset;
    logic accumulate;
  } mac_ctl_t;

endpackage : fpc_pkg

`default_nettype wire

// File: sv/fpc_if.sv
// Interfaces: input item channel and result channel with valid/ready handshake.
`default_nettype none

interface fpc_in_if import fpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [IDX_W-1:0]         plane_index;
  logic signed [DATA_W-1:0] val_a;
  logic signed [DATA_W-1:0] val_b;
  logic signed [DATA_W-1:0] val_c;
  logic signed [DATA_W-1:0] val_d;
  logic signed [DATA_W-1:0] val_e;
  logic signed [DATA_W-1:0] val_f;

  modport source (
    output valid, opcode, plane_index, val_a, val_b, val_c, val_d, val_e, val_f,
    input  ready
  );
  modport sink (
    input  valid, opcode, plane_index, val_a, val_b, val_c, val_d, val_e, val_f,
    output ready
  );
endinterface : fpc_in_if

interface fpc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface : fpc_out_if

`default_nettype wire

// File: sv/fpc_mac.sv
// Shared multiply-accumulate unit: one signed 32x32 product per cycle into a wide sum.
`default_nettype none

module fpc_mac import fpc_pkg::*; (
  input  wire logic                     clk,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [ACC_W-1:0]  offset,
  input  wire logic signed [DATA_W-1:0] coef,
  input  wire logic signed [DATA_W-1:0] coord,
  output logic signed [ACC_W-1:0]       total
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  assign total = acc + ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod <= coef * coord;
    if (ctl.load_offset) begin
      acc <= offset;
    end else if (ctl.accumulate) begin
      acc <= total;
    end
  end

endmodule : fpc_mac

`default_nettype wire

// File: sv/frustum_plane_cull_top.sv
// Top level: plane table, cull sequencer and result register.
// Load or unused opcode: no result. Test: steps A, B, C and sum per plane on the shared
// multiplier, stop at the first plane that culls; the result is registered once the last
// plane is tested (at most NUM_PLANES planes), and the next item is taken after the result
// is written; a held result stalls the write. Synchronous active-high reset clears the sequencer
// and the result valid flag; the plane table is not cleared and must be loaded before use.
`default_nettype none

module frustum_plane_cull_top import fpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  fpc_in_if.sink    req,
  fpc_out_if.source rsp
);

  logic signed [DATA_W-1:0] plane_a [NUM_PLANES];
  logic signed [DATA_W-1:0] plane_b [NUM_PLANES];
  logic signed [DATA_W-1:0] plane_c [NUM_PLANES];
  logic signed [DATA_W-1:0] plane_d [NUM_PLANES];

  state_t                   state;
  state_t                   state_next;
  step_t                    step;
  logic [PLANE_W-1:0]       plane;
  logic                     is_box;
  logic                     vis_pend;
  logic                     out_valid;
  logic                     out_vis;

  logic signed [DATA_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic signed [DATA_W-1:0] extra;

  logic                     accept;
  logic                     is_load;
  logic                     is_test;
  logic                     culled;
  logic                     last_plane;
  logic                     plane_done;
  logic                     out_free;
  mac_ctl_t                 mac_ctl;
  logic signed [DATA_W-1:0] coef;
  logic signed [DATA_W-1:0] lo_sel;
  logic signed [DATA_W-1:0] hi_sel;
  logic signed [DATA_W-1:0] coord;
  logic signed [DATA_W:0]   off_sum;
  logic signed [ACC_W-1:0]  offset;
  logic signed [ACC_W-1:0]  total;

  assign accept     = req.valid && req.ready;
  assign is_load    = req.opcode == OP_LOAD;
  assign is_test    = (req.opcode == OP_SPHERE) || (req.opcode == OP_BOX);
  assign out_free   = !out_valid || rsp.ready;
  assign last_plane = plane == PLANE_W'(NUM_PLANES - 1);
  assign plane_done = (state == ST_RUN) && (step == STEP_SUM);
  assign culled     = is_box ? (total[ACC_W-1] || (total == '0)) : total[ACC_W-1];

  always_comb begin
    unique case (step)
      STEP_A: begin
        coef = plane_a[plane];
        lo_sel = lo_x;
        hi_sel = hi_x;
      end
      STEP_B: begin
        coef = plane_b[plane];
        lo_sel = lo_y;
        hi_sel = hi_y;
      end
      STEP_C: begin
        coef = plane_c[plane];
        lo_sel = lo_z;
        hi_sel = hi_z;
      end
      default: begin
        coef = plane_d[plane];
        lo_sel = lo_z;
        hi_sel = hi_z;
      end
    endcase
    coord   = coef[DATA_W-1] ? lo_sel : hi_sel;
    off_sum = (DATA_W+1)'(plane_d[plane]) + (DATA_W+1)'(extra);
    offset  = ACC_W'(off_sum) <<< FRAC_W;
  end

  fpc_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .offset (offset),
    .coef   (coef),
    .coord  (coord),
    .total  (total)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_test) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (plane_done && (culled || last_plane)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready           = state == ST_IDLE;
    mac_ctl.load_offset = (state == ST_RUN) && (step == STEP_A);
    mac_ctl.accumulate  = (state == ST_RUN) && ((step == STEP_B) || (step == STEP_C));
    rsp.valid           = out_valid;
    rsp.visible         = out_vis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_A;
      plane     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        step  <= STEP_A;
        plane <= '0;
      end else if (state == ST_RUN) begin
        step <= step_t'(step + 2'd1);
        if (plane_done) begin
          plane <= plane + PLANE_W'(1);
        end
      end
      if ((state == ST_WRITE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && ({1'b0, req.plane_index} < (IDX_W+1)'(NUM_PLANES))) begin
      plane_a[req.plane_index[PLANE_W-1:0]] <= req.val_a;
      plane_b[req.plane_index[PLANE_W-1:0]] <= req.val_b;
      plane_c[req.plane_index[PLANE_W-1:0]] <= req.val_c;
      plane_d[req.plane_index[PLANE_W-1:0]] <= req.val_d;
    end
    if (accept && is_test) begin
      is_box   <= req.opcode == OP_BOX;
      vis_pend <= 1'b1;
      if (req.opcode == OP_BOX) begin
        extra <= '0;
        lo_x  <= (req.val_a < req.val_b) ? req.val_a : req.val_b;
        hi_x  <= (req.val_a < req.val_b) ? req.val_b : req.val_a;
        lo_y  <= (req.val_c < req.val_d) ? req.val_c : req.val_d;
        hi_y  <= (req.val_c < req.val_d) ? req.val_d : req.val_c;
        lo_z  <= (req.val_e < req.val_f) ? req.val_e : req.val_f;
        hi_z  <= (req.val_e < req.val_f) ? req.val_f : req.val_e;
      end else begin
        extra <= req.val_d;
        lo_x  <= req.val_a;
        hi_x  <= req.val_a;
        lo_y  <= req.val_b;
        hi_y  <= req.val_b;
        lo_z  <= req.val_c;
        hi_z  <= req.val_c;
      end
    end else if (plane_done && culled) begin
      vis_pend <= 1'b0;
    end
    if ((state == ST_WRITE) && out_free) begin
      out_vis <= vis_pend;
    end
  end

endmodule : frustum_plane_cull_top

`default_nettype wire
